/* rtl/core/acmac_pkg.sv */
`default_nettype none
package acmac_pkg;

    localparam logic [7:0] RB_CONST = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    localparam logic [3:0] ADDR_KEY_HIGH = 4'd0;
    localparam logic [3:0] ADDR_KEY_LOW  = 4'd8;

    // word queued from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } acmac_item_t;

    typedef struct packed {
        logic key_changed;
    } acmac_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block, byte 0 most significant
    function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] round_fn(input logic [127:0] st, input logic [127:0] rk,
                                              input logic last);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = sbox(blk_byte(st, i));
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) t[c*4+j] = s[((c + j) & 3)*4 + j];
        for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            o[c*4]   = last ? a0 : a0 ^ al ^ xtime(a0 ^ a1);
            o[c*4+1] = last ? a1 : a1 ^ al ^ xtime(a1 ^ a2);
            o[c*4+2] = last ? a2 : a2 ^ al ^ xtime(a2 ^ a3);
            o[c*4+3] = last ? a3 : a3 ^ al ^ xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = o[i];
        return r ^ rk;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tw; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ {120'd0, x[127] ? RB_CONST : 8'h00};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/acmac_aes.sv */
`default_nettype none
module acmac_aes
    import acmac_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [127:0] key,
    input  wire logic [127:0] din,
    output logic              busy,
    output logic              done,
    output logic [127:0]      dout
);
    logic [127:0] st_reg, st_next, rk_reg, rk_next;
    logic [7:0]   rc_reg, rc_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next, done_reg, done_next;
    logic [127:0] rk_cur;

    assign rk_cur = key_step(rk_reg, rc_reg);

    always_comb begin
        st_next = st_reg; rk_next = rk_reg; rc_next = rc_reg;
        rnd_next = rnd_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start && !busy_reg) begin
            st_next = din ^ key; rk_next = key; rc_next = 8'h01;
            rnd_next = 4'd1; busy_next = 1'b1;
        end else if (busy_reg) begin
            st_next = round_fn(st_reg, rk_cur, rnd_reg == 4'd10);
            rk_next = rk_cur;
            rc_next = xtime(rc_reg);
            rnd_next = rnd_reg + 4'd1;
            if (rnd_reg == 4'd10) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next; rk_reg <= rk_next; rc_reg <= rc_next; rnd_reg <= rnd_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign dout = st_reg;
endmodule
`default_nettype wire

/* rtl/core/acmac_front.sv */
`default_nettype none
module acmac_front
    import acmac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    output logic             q_valid,
    input  wire logic        q_pop,
    output acmac_item_t      q_item
);
    // two-entry queue; idle items (no byte, no end) are dropped here
    acmac_item_t mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        push;

    assign s_tready = cnt_reg != 2'd2;
    assign push = s_tvalid && s_tready && (s_tuser || s_tlast);
    assign q_valid = cnt_reg != 2'd0;
    assign q_item = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= '{data_byte: s_tdata, has_byte: s_tuser,
                                       end_of_message: s_tlast};
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop && q_valid) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end
endmodule
`default_nettype wire

/* rtl/core/acmac_back.sv */
`default_nettype none
module acmac_back
    import acmac_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [127:0] key,
    input  wire acmac_ctrl_t  ctrl,
    input  wire logic         q_valid,
    output logic              q_pop,
    input  wire acmac_item_t  q_item,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_SUBK = 6'b000010, S_CHAIN = 6'b000100,
        S_TAG = 6'b001000, S_OUT0 = 6'b010000, S_OUT1 = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [127:0] chain_reg, buf_reg, k1_reg, tag_reg;
    logic [4:0]   fill_reg;
    logic         ready_reg;
    logic         aes_start, aes_busy, aes_done;
    logic [127:0] aes_din, aes_dout, padded, fin;

    acmac_aes u_aes (.aclk, .aresetn, .start(aes_start), .key, .din(aes_din),
                     .busy(aes_busy), .done(aes_done), .dout(aes_dout));

    always_comb begin
        padded = buf_reg;
        padded[127 - 8*fill_reg[3:0] -: 8] = PAD_BYTE;
        fin = (fill_reg == BLOCK_BYTES) ? buf_reg ^ k1_reg : padded ^ dbl(k1_reg);
    end

    always_comb begin
        state_next = state_reg; aes_start = 1'b0; aes_din = '0; q_pop = 1'b0;
        case (state_reg)
            S_IDLE: if (q_valid) begin
                if (!ready_reg) begin
                    aes_start = 1'b1; state_next = S_SUBK;
                end else if (q_item.has_byte && fill_reg == BLOCK_BYTES) begin
                    aes_start = 1'b1; aes_din = chain_reg ^ buf_reg; state_next = S_CHAIN;
                end else if (q_item.has_byte) begin
                    q_pop = !q_item.end_of_message;
                    if (q_item.end_of_message) state_next = S_TAG;
                end else begin
                    state_next = S_TAG;
                end
            end
            S_SUBK:  if (aes_done) state_next = S_IDLE;
            S_CHAIN: if (aes_done) state_next = S_IDLE;
            S_TAG: if (!aes_busy && !aes_done) begin
                aes_start = 1'b1; aes_din = chain_reg ^ fin; q_pop = 1'b1;
                state_next = S_OUT0;
            end
            S_OUT0: if (m_tready && !aes_busy && !aes_done) state_next = S_OUT1;
            S_OUT1: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (aes_done) tag_reg <= aes_dout;
        if (state_reg == S_SUBK && aes_done) k1_reg <= dbl(aes_dout);
        if (!aresetn) begin
            state_reg <= S_IDLE; chain_reg <= '0; buf_reg <= '0; fill_reg <= '0;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctrl.key_changed) ready_reg <= 1'b0;
            else if (state_reg == S_SUBK && aes_done) ready_reg <= 1'b1;
            if (state_reg == S_CHAIN && aes_done) begin
                chain_reg <= aes_dout; buf_reg <= '0; fill_reg <= '0;
            end
            if (state_reg == S_IDLE && q_valid && ready_reg && q_item.has_byte &&
                fill_reg != BLOCK_BYTES) begin
                buf_reg[127 - 8*fill_reg[3:0] -: 8] <= q_item.data_byte;
                fill_reg <= fill_reg + 5'd1;
            end
            if (state_reg == S_TAG && aes_start) begin
                chain_reg <= '0; buf_reg <= '0; fill_reg <= '0;
            end
        end
    end

    assign m_tvalid = (state_reg == S_OUT0 && !aes_busy && !aes_done) || state_reg == S_OUT1;
    assign m_tdata  = (state_reg == S_OUT1) ? tag_reg[63:0] : tag_reg[127:64];
    assign m_tuser  = state_reg == S_OUT1;
    assign m_tlast  = state_reg == S_OUT1;
endmodule
`default_nettype wire

/* rtl/core/aes_cmac_tag_unit.sv */
`default_nettype none
// AES-128 CMAC (RFC 4493) over a byte stream. A two-word input queue feeds a
// sequencer around one iterative AES unit (one round per cycle). Bytes inside a
// block go straight into the block buffer; the byte that follows a full block
// waits for its chaining encryption, the first item after a key write for
// subkey derivation, and the end of a message for the tag encryption before the
// two 64-bit tag words appear on m_.
module aes_cmac_tag_unit
    import acmac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // has_byte
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // tag_word
    output logic             m_tuser,   // word_index
    output logic             m_tlast,   // last_word
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic [63:0] key_high_reg, key_low_reg;
    logic        wr;
    acmac_ctrl_t ctrl;
    logic        q_valid, q_pop;
    acmac_item_t q_item;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign ctrl.key_changed = wr && (paddr == ADDR_KEY_HIGH || paddr == ADDR_KEY_LOW);
    assign prdata = (paddr == ADDR_KEY_HIGH) ? key_high_reg :
                    (paddr == ADDR_KEY_LOW) ? key_low_reg : 64'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0; key_low_reg <= '0;
        end else if (wr) begin
            if (paddr == ADDR_KEY_HIGH) key_high_reg <= pwdata;
            if (paddr == ADDR_KEY_LOW) key_low_reg <= pwdata;
        end
    end

    acmac_front u_front (.aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
                         .s_tlast, .q_valid, .q_pop, .q_item);

    acmac_back u_back (.aclk, .aresetn, .key({key_high_reg, key_low_reg}), .ctrl,
                       .q_valid, .q_pop, .q_item, .m_tvalid, .m_tready, .m_tdata,
                       .m_tuser, .m_tlast);

    a_last_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && !m_tuser))
        else $error("tag words out of order");
    a_index_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == m_tlast)
        else $error("word index and last disagree");
endmodule
`default_nettype wire
